### rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants for the text console cursor engine: screen geometry
// defaults, field widths, item kinds, control codes and register indexes.
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// field widths of the stream payload
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;
	localparam int KIND_W  = 2;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_PRINT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// control codes
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

	// register indexes
	localparam logic REG_TEXT_ATTR  = 1'b0;
	localparam logic REG_BLANK_ATTR = 1'b1;

	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

endpackage

### rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text-mode screen store with a cursor: prints bytes, clears the screen
// and reads cells, scrolling the screen when the cursor runs off the end.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the item kind (print, clear, read), s_tdata
// the byte to print and the cell index to read. Each accepted item gives one
// result on the output stream: cursor column, cursor row and, for reads, the
// cell (attribute in the high byte); other kinds return a zero cell.
// An ordinary item passes through an execute state, on the single screen
// memory port pair, and a done state that hands the result to the output
// register; the next item is accepted in the done state as the result loads.
// A read past the store returns a zero cell.
// A scroll walks the memory through its one read and one write port,
// copying each cell below the top row one row up and then blanking the
// bottom row; a clear screen blanks every cell. Input is held off
// (s_tready low) during these passes.
// After reset a clearing pass fills the store with blank cells before the
// first item is accepted; register writes on the cfg port are taken at
// any time.
// If the receiver stalls, the result waits in the output register; one more
// item is accepted and executed, then the block holds until the slot frees.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
	parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_wen,
	input  logic                          cfg_index,
	input  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tcce_pkg::S_DATA_W-1:0] s_tdata,  // char_code[7:0], cell_index[18:8]
	input  logic [tcce_pkg::KIND_W-1:0]   s_tuser,  // kind[1:0]
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tcce_pkg::M_DATA_W-1:0] m_tdata   // cursor_col[6:0], cursor_row[11:7],
	                                                // cell_data[27:12]
);

	import tcce_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_SCROLL = 6'b001000,
		ST_FILL   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [ATTR_W-1:0]  text_attr_q;
	logic [ATTR_W-1:0]  blank_attr_q;

	logic [KIND_W-1:0]  kind_q;
	logic [CHAR_W-1:0]  char_q;
	logic [INDEX_W-1:0] index_q;

	logic [COL_W-1:0]   col_q, col_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [CNT_W-1:0]   ptr_q, ptr_d;
	logic               rd_ok_q, rd_ok_d;

	logic [CELL_W-1:0]  mem [CELLS];
	logic [CELL_W-1:0]  rd_data_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [CELL_W-1:0]  mem_wdata;

	logic               m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic               in_xfer;
	logic               out_free;
	logic               out_load;
	logic               index_ok;
	logic               at_origin;
	logic               last_col;
	logic               last_row;
	logic [COL_W-1:0]   bs_col;
	logic [ROW_W-1:0]   bs_row;
	logic [COL_W-1:0]   put_col;
	logic [ROW_W-1:0]   put_row;
	logic [ADDR_W-1:0]  put_addr;
	logic [CELL_W-1:0]  out_cell;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q  <= RESET_ATTR;
			blank_attr_q <= RESET_ATTR;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_TEXT_ATTR:  text_attr_q  <= cfg_wdata;
				REG_BLANK_ATTR: blank_attr_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------------
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign s_tready = (state_q == ST_IDLE) || out_load;
	assign in_xfer  = s_tvalid && s_tready;

	// ------------------------------------------------------------------------
	// cursor arithmetic
	// ------------------------------------------------------------------------
	assign at_origin = (col_q == '0) && (row_q == '0);
	assign last_col  = (col_q == COL_W'(COLUMNS - 1));
	assign last_row  = (row_q == ROW_W'(ROWS - 1));
	assign index_ok  = (32'(index_q) < 32'(CELLS));

	// backspace target: step back, wrapping to the end of the previous row
	always_comb begin
		if (col_q == '0) begin
			bs_col = COL_W'(COLUMNS - 1);
			bs_row = row_q - ROW_W'(1);
		end else begin
			bs_col = col_q - COL_W'(1);
			bs_row = row_q;
		end
	end

	assign put_col  = (char_q == CODE_BACKSPACE) ? bs_col : col_q;
	assign put_row  = (char_q == CODE_BACKSPACE) ? bs_row : row_q;
	assign put_addr = ADDR_W'(32'(put_row) * COLUMNS + 32'(put_col));

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		ptr_d     = ptr_q;
		rd_ok_d   = rd_ok_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;

		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[ADDR_W-1:0];
				mem_wdata = {RESET_ATTR, CODE_SPACE};
				if (ptr_q == CNT_W'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end

			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				rd_ok_d = 1'b0;
				state_d = ST_DONE;
				case (kind_q)
					KIND_PRINT: begin
						if (char_q == CODE_NEWLINE) begin
							col_d = '0;
							if (last_row) begin
								state_d = ST_SCROLL;
								ptr_d   = CNT_W'(COLUMNS);
							end else begin
								row_d = row_q + ROW_W'(1);
							end
						end else if (char_q == CODE_BACKSPACE) begin
							// ignore backspace at the top-left corner
							if (!at_origin) begin
								mem_we    = 1'b1;
								mem_waddr = put_addr;
								mem_wdata = {text_attr_q, CODE_SPACE};
								col_d     = bs_col;
								row_d     = bs_row;
							end
						end else begin
							mem_we    = 1'b1;
							mem_waddr = put_addr;
							mem_wdata = {text_attr_q, char_q};
							if (last_col) begin
								col_d = '0;
								if (last_row) begin
									state_d = ST_SCROLL;
									ptr_d   = CNT_W'(COLUMNS);
								end else begin
									row_d = row_q + ROW_W'(1);
								end
							end else begin
								col_d = col_q + COL_W'(1);
							end
						end
					end
					KIND_CLEAR: begin
						col_d   = '0;
						row_d   = '0;
						ptr_d   = '0;
						state_d = ST_FILL;
					end
					KIND_READ: begin
						rd_en   = index_ok;
						rd_addr = index_ok ? ADDR_W'(index_q) : '0;
						rd_ok_d = index_ok;
					end
					default: ;
				endcase
			end

			ST_SCROLL: begin
				// read cell ptr, write the cell read last cycle one row up
				if (ptr_q != CNT_W'(CELLS)) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q[ADDR_W-1:0];
				end
				if (ptr_q > CNT_W'(COLUMNS)) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(ptr_q - CNT_W'(COLUMNS + 1));
					mem_wdata = rd_data_q;
				end
				if (ptr_q == CNT_W'(CELLS)) begin
					state_d = ST_FILL;
					ptr_d   = CNT_W'((ROWS - 1) * COLUMNS);
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end

			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[ADDR_W-1:0];
				mem_wdata = {blank_attr_q, CODE_SPACE};
				if (ptr_q == CNT_W'(CELLS - 1)) begin
					state_d = ST_DONE;
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end

			ST_DONE: begin
				if (out_load) begin
					state_d = in_xfer ? ST_EXEC : ST_IDLE;
				end
			end

			default: begin
				state_d = ST_INIT;
				ptr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			col_q   <= '0;
			row_q   <= '0;
			ptr_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			ptr_q   <= ptr_d;
			rd_ok_q <= rd_ok_d;
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= s_tuser;
			char_q  <= s_tdata[CHAR_W-1:0];
			index_q <= s_tdata[CHAR_W +: INDEX_W];
		end
	end

	// ------------------------------------------------------------------------
	// screen memory
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	assign out_cell = rd_ok_q ? rd_data_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'b0000, out_cell, row_q, col_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(COLUMNS)) && (32'(row_q) < 32'(ROWS)))
		else $error("cursor outside the screen");

	a_accept_executes: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_EXEC))
		else $error("accepted transaction not executed");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

endmodule
